// ===== hw/rtl/gom_pkg.sv =====
`default_nettype none

package gom_pkg;

    // Geometry of the line stores
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = 10;
    localparam int ROW_W     = 12;
    localparam int WID_W     = 11;
    localparam int ADDR_W    = COL_W + 1;

    // Datapath widths
    localparam int PIX_W   = 8;
    localparam int GRAD_W  = 9;
    localparam int SMTH_W  = 11;
    localparam int PROD_W  = 22;
    localparam int TERM_W  = 23;
    localparam int CSUM_W  = 25;
    localparam int VEC_W   = 26;
    localparam int MAG_W   = 26;
    localparam int HALF_W  = 17;
    localparam int PPROD_W = MAG_W + HALF_W;
    localparam int FULL_W  = PPROD_W + HALF_W;
    localparam int IDX_W   = 5;
    localparam int CODE_W  = 8;

    // Angle constants
    localparam logic [IDX_W-1:0]  TAN_LAST    = 5'd22;
    localparam logic [CODE_W-1:0] ORIENT_BASE = 8'd74;
    localparam logic [CODE_W-1:0] ORIENT_CAP  = 8'd252;
    localparam logic [CODE_W-1:0] ORIENT_ZERO = 8'd164;
    localparam logic [CODE_W-1:0] QUAD_STEP   = 8'd45;

    // Register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic             take;
        logic             mem_rd;
        logic             grad_step;
        logic             mul_step;
        logic             sum_step;
        logic             quad_step;
        logic             ang_hi;
        logic             ang_lo;
        logic             ang_acc;
        logic             ang_cmp;
        logic [IDX_W-1:0] tan_idx;
        logic             out_load;
    } gom_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic emit;
        logic out_busy;
    } gom_stat_t;

    // Index 0 is the unit scale 10^10, indexes 1..22 are tan(2j deg) * 10^10
    function automatic logic [2*HALF_W-1:0] tan_k(input logic [IDX_W-1:0] j);
        logic [2*HALF_W-1:0] v;
        case (j)
            5'd0:    v = 34'd10000000000;
            5'd1:    v = 34'd349207695;
            5'd2:    v = 34'd699268119;
            5'd3:    v = 34'd1051042353;
            5'd4:    v = 34'd1405408347;
            5'd5:    v = 34'd1763269807;
            5'd6:    v = 34'd2125565617;
            5'd7:    v = 34'd2493280028;
            5'd8:    v = 34'd2867453858;
            5'd9:    v = 34'd3249196962;
            5'd10:   v = 34'd3639702343;
            5'd11:   v = 34'd4040262258;
            5'd12:   v = 34'd4452286853;
            5'd13:   v = 34'd4877325886;
            5'd14:   v = 34'd5317094317;
            5'd15:   v = 34'd5773502692;
            5'd16:   v = 34'd6248693519;
            5'd17:   v = 34'd6745085168;
            5'd18:   v = 34'd7265425280;
            5'd19:   v = 34'd7812856265;
            5'd20:   v = 34'd8390996312;
            5'd21:   v = 34'd9004040443;
            5'd22:   v = 34'd9656887748;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gom_ctrl.sv =====
`default_nettype none

module gom_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire gom_pkg::gom_stat_t st,
    output gom_pkg::gom_cmd_t       cmd
);
    import gom_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_GRAD, S_MUL, S_SUM, S_QUAD,
        S_AHI, S_ALO, S_AACC, S_ACMP, S_OUT
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    assign in_stall = (state_reg != S_IDLE);

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.tan_idx = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_GRAD;
            end
            S_GRAD:
            begin
                cmd.grad_step = 1'b1;
                state_next    = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next   = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
                state_next   = st.emit ? S_QUAD : S_IDLE;
            end
            S_QUAD:
            begin
                cmd.quad_step = 1'b1;
                idx_next      = '0;
                state_next    = S_AHI;
            end
            S_AHI:
            begin
                cmd.ang_hi = 1'b1;
                state_next = S_ALO;
            end
            S_ALO:
            begin
                cmd.ang_lo = 1'b1;
                state_next = S_AACC;
            end
            S_AACC:
            begin
                cmd.ang_acc = 1'b1;
                state_next  = S_ACMP;
            end
            S_ACMP:
            begin
                cmd.ang_cmp = 1'b1;
                if (idx_reg == TAN_LAST)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_AHI;
                end
            end
            S_OUT:
            begin
                if (!st.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and table index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gom_datapath.sv =====
`default_nettype none

module gom_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire gom_pkg::gom_cmd_t            cmd,
    output gom_pkg::gom_stat_t                st,
    input  wire logic                         cfg_valid,
    input  wire logic                         cfg_index,
    input  wire logic [gom_pkg::ROW_W-1:0]    cfg_data,
    input  wire logic [gom_pkg::PIX_W-1:0]    pixel,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [gom_pkg::CODE_W-1:0]        orient_code,
    output logic [gom_pkg::COL_W-1:0]         col,
    output logic [gom_pkg::ROW_W-1:0]         row,
    output logic                              frame_last
);
    import gom_pkg::*;

    // Line stores: pixels, Dx, and tensor term pairs, two rows each
    logic [PIX_W-1:0]        pix_mem  [2*MAX_WIDTH];
    logic signed [GRAD_W-1:0] grad_mem [2*MAX_WIDTH];
    logic [2*TERM_W-1:0]     term_mem [2*MAX_WIDTH];

    logic [WID_W-1:0] width_reg;
    logic [ROW_W-1:0] height_reg;
    logic [COL_W-1:0] colcnt_reg;
    logic [ROW_W-1:0] rowcnt_reg;

    logic [PIX_W-1:0] p_reg;
    logic [COL_W-1:0] c_reg;
    logic [ROW_W-1:0] r_reg;
    logic dy_en_reg, dx_en_reg, gen_reg, emit_reg, last_reg;

    logic [PIX_W-1:0]         pa_reg, pb_reg;
    logic signed [GRAD_W-1:0] gs_reg, go_reg;
    logic [2*TERM_W-1:0]      ts_reg, to_reg;

    logic signed [GRAD_W-1:0] dyd1_reg, dyd2_reg;
    logic signed [SMTH_W-1:0] sx_reg, sy_reg;
    logic signed [PROD_W-1:0] mxy_reg, mxx_reg, myy_reg;
    logic signed [CSUM_W-1:0] csp0_reg, csp1_reg, csq0_reg, csq1_reg;
    logic signed [VEC_W-1:0]  vx_reg, vy_reg;

    logic [MAG_W-1:0]   x_reg, y_reg;
    logic [CODE_W-1:0]  k_reg;
    logic               zero_reg;
    logic [PPROD_W-1:0] prx_reg, pry_reg, acx_reg, acy_reg;
    logic [FULL_W-1:0]  smx_reg, smy_reg, x10_reg, y10_reg;

    logic                 out_valid_reg;
    logic [CODE_W-1:0]    code_reg;
    logic [COL_W-1:0]     ocol_reg;
    logic [ROW_W-1:0]     orow_reg;
    logic                 olast_reg;

    // Differences, tensor terms and column sums of the current pixel
    logic signed [GRAD_W-1:0] dx_v, dy_v;
    logic signed [TERM_W-1:0] tp_v, tq_v;
    logic signed [CSUM_W-1:0] cp_v, cq_v;

    // Frame size in use
    logic [WID_W-1:0] w_use;
    logic [ROW_W-1:0] h_use;
    logic [12:0] c_ext, r_ext, w_ext, h_ext;
    logic        s_bit;
    logic [COL_W-1:0] ci;

    always_comb
    begin
        if (width_reg < WID_W'(5))
            w_use = WID_W'(5);
        else if (width_reg > WID_W'(MAX_WIDTH))
            w_use = WID_W'(MAX_WIDTH);
        else
            w_use = width_reg;
        h_use = (height_reg < ROW_W'(5)) ? ROW_W'(5) : height_reg;
        c_ext = 13'(colcnt_reg);
        r_ext = 13'(rowcnt_reg);
        w_ext = 13'(w_use);
        h_ext = 13'(h_use);
    end

    assign s_bit = r_reg[0];
    assign ci    = c_reg - 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WID_W'(640);
            height_reg <= ROW_W'(480);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[WID_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data;
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    // Position counters and per-pixel flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colcnt_reg <= '0;
            rowcnt_reg <= '0;
            dy_en_reg  <= 1'b0;
            dx_en_reg  <= 1'b0;
            gen_reg    <= 1'b0;
            emit_reg   <= 1'b0;
            last_reg   <= 1'b0;
        end
        else if (cmd.take)
        begin
            dy_en_reg <= (c_ext >= 13'd1) && (c_ext + 13'd2 <= w_ext)
                      && (r_ext >= 13'd2) && (r_ext + 13'd1 <= h_ext);
            dx_en_reg <= (c_ext >= 13'd2) && (c_ext + 13'd1 <= w_ext)
                      && (r_ext >= 13'd1) && (r_ext + 13'd2 <= h_ext);
            gen_reg   <= (c_ext >= 13'd1);
            emit_reg  <= (c_ext >= 13'd4) && (c_ext + 13'd1 <= w_ext)
                      && (r_ext >= 13'd4) && (r_ext + 13'd1 <= h_ext);
            last_reg  <= (c_ext + 13'd1 == w_ext) && (r_ext + 13'd1 == h_ext);
            if (c_ext + 13'd1 >= w_ext)
            begin
                colcnt_reg <= '0;
                rowcnt_reg <= (r_ext + 13'd1 >= h_ext) ? '0 : rowcnt_reg + 1'b1;
            end
            else
            begin
                colcnt_reg <= colcnt_reg + 1'b1;
            end
        end
    end

    // Latched transaction
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            p_reg <= pixel;
            c_reg <= colcnt_reg;
            r_reg <= rowcnt_reg;
        end
    end

    // Memory reads and writes
    always_ff @(posedge clk)
    begin
        if (cmd.mem_rd)
        begin
            pa_reg <= pix_mem[{s_bit, c_reg}];
            pb_reg <= pix_mem[{s_bit, c_reg - COL_W'(2)}];
            gs_reg <= grad_mem[{s_bit, ci}];
            go_reg <= grad_mem[{~s_bit, ci}];
            ts_reg <= term_mem[{s_bit, ci}];
            to_reg <= term_mem[{~s_bit, ci}];
        end
        if (cmd.grad_step)
        begin
            pix_mem[{s_bit, c_reg}] <= p_reg;
            if (gen_reg)
                grad_mem[{s_bit, ci}] <= dx_v;
        end
        if (cmd.sum_step && gen_reg)
            term_mem[{~s_bit, ci}] <= {tp_v, tq_v};
    end

    // Differences and smoothing
    always_comb
    begin
        dy_v = dy_en_reg ? (GRAD_W'(p_reg) - GRAD_W'(pa_reg)) : '0;
        dx_v = dx_en_reg ? (GRAD_W'(p_reg) - GRAD_W'(pb_reg)) : '0;
        tp_v = TERM_W'(mxy_reg) <<< 1;
        tq_v = TERM_W'(mxx_reg) - TERM_W'(myy_reg);
        cp_v = CSUM_W'($signed(to_reg[2*TERM_W-1:TERM_W]))
             + CSUM_W'($signed(ts_reg[2*TERM_W-1:TERM_W])) + CSUM_W'(tp_v);
        cq_v = CSUM_W'($signed(to_reg[TERM_W-1:0]))
             + CSUM_W'($signed(ts_reg[TERM_W-1:0])) + CSUM_W'(tq_v);
    end

    // Row pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dyd1_reg <= '0;
            dyd2_reg <= '0;
            csp0_reg <= '0;
            csp1_reg <= '0;
            csq0_reg <= '0;
            csq1_reg <= '0;
        end
        else
        begin
            if (cmd.grad_step)
            begin
                dyd2_reg <= dyd1_reg;
                dyd1_reg <= dy_v;
            end
            if (cmd.sum_step && gen_reg)
            begin
                csp1_reg <= csp0_reg;
                csp0_reg <= cp_v;
                csq1_reg <= csq0_reg;
                csq0_reg <= cq_v;
            end
        end
    end

    // Smoothed gradients, products, window sums
    always_ff @(posedge clk)
    begin
        if (cmd.grad_step)
        begin
            sy_reg <= SMTH_W'(dyd2_reg) + (SMTH_W'(dyd1_reg) <<< 1) + SMTH_W'(dy_v);
            sx_reg <= SMTH_W'(gs_reg) + (SMTH_W'(go_reg) <<< 1) + SMTH_W'(dx_v);
        end
        if (cmd.mul_step)
        begin
            mxy_reg <= PROD_W'(sx_reg) * PROD_W'(sy_reg);
            mxx_reg <= PROD_W'(sx_reg) * PROD_W'(sx_reg);
            myy_reg <= PROD_W'(sy_reg) * PROD_W'(sy_reg);
        end
        if (cmd.sum_step)
        begin
            vx_reg <= VEC_W'(csp1_reg) + VEC_W'(csp0_reg) + VEC_W'(cp_v);
            vy_reg <= VEC_W'(csq1_reg) + VEC_W'(csq0_reg) + VEC_W'(cq_v);
        end
    end

    // Quadrant fold of (-vx, vy)
    logic signed [VEC_W:0] u_v, w_v, nu_v, nw_v;
    always_comb
    begin
        u_v  = -(VEC_W+1)'(vx_reg);
        w_v  = (VEC_W+1)'(vy_reg);
        nu_v = -u_v;
        nw_v = -w_v;
    end

    // Angle search: exact products against the tangent table
    logic [2*HALF_W-1:0] kc;
    assign kc = tan_k(cmd.tan_idx);

    always_ff @(posedge clk)
    begin
        if (cmd.quad_step)
        begin
            zero_reg <= (u_v == '0) && (w_v == '0);
            if (u_v > 0 && w_v >= 0)
            begin
                x_reg <= u_v[MAG_W-1:0];
                y_reg <= w_v[MAG_W-1:0];
                k_reg <= '0;
            end
            else if (u_v <= 0 && w_v > 0)
            begin
                x_reg <= w_v[MAG_W-1:0];
                y_reg <= nu_v[MAG_W-1:0];
                k_reg <= QUAD_STEP;
            end
            else if (u_v < 0 && w_v <= 0)
            begin
                x_reg <= nu_v[MAG_W-1:0];
                y_reg <= nw_v[MAG_W-1:0];
                k_reg <= QUAD_STEP + QUAD_STEP;
            end
            else
            begin
                x_reg <= nw_v[MAG_W-1:0];
                y_reg <= u_v[MAG_W-1:0];
                k_reg <= QUAD_STEP + QUAD_STEP + QUAD_STEP;
            end
        end
        if (cmd.ang_hi)
        begin
            prx_reg <= PPROD_W'(x_reg) * PPROD_W'(kc[2*HALF_W-1:HALF_W]);
            pry_reg <= PPROD_W'(y_reg) * PPROD_W'(kc[2*HALF_W-1:HALF_W]);
        end
        if (cmd.ang_lo)
        begin
            acx_reg <= prx_reg;
            acy_reg <= pry_reg;
            prx_reg <= PPROD_W'(x_reg) * PPROD_W'(kc[HALF_W-1:0]);
            pry_reg <= PPROD_W'(y_reg) * PPROD_W'(kc[HALF_W-1:0]);
        end
        if (cmd.ang_acc)
        begin
            smx_reg <= {acx_reg, {HALF_W{1'b0}}} + FULL_W'(prx_reg);
            smy_reg <= {acy_reg, {HALF_W{1'b0}}} + FULL_W'(pry_reg);
        end
        if (cmd.ang_cmp)
        begin
            if (cmd.tan_idx == '0)
            begin
                x10_reg <= smx_reg;
                y10_reg <= smy_reg;
            end
            else
            begin
                k_reg <= k_reg + CODE_W'(y10_reg >= smx_reg) + CODE_W'(x10_reg <= smy_reg);
            end
        end
    end

    // Output register
    logic [CODE_W:0] code_sum;
    assign code_sum = (CODE_W+1)'(ORIENT_BASE) + (CODE_W+1)'(k_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (zero_reg)
                code_reg <= ORIENT_ZERO;
            else if (code_sum > (CODE_W+1)'(ORIENT_CAP))
                code_reg <= ORIENT_CAP;
            else
                code_reg <= code_sum[CODE_W-1:0];
            ocol_reg  <= c_reg - COL_W'(2);
            orow_reg  <= r_reg - ROW_W'(2);
            olast_reg <= last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign orient_code = code_reg;
    assign col         = ocol_reg;
    assign row         = orow_reg;
    assign frame_last  = olast_reg;

    assign st.emit     = emit_reg;
    assign st.out_busy = out_valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/gradient_orientation_map_unit.sv =====
// Channel  Handshake           Payload
// in       in_valid/in_stall   pixel[7:0]
// out      out_valid/out_stall orient_code[7:0], col[9:0], row[11:0], frame_last
// cfg      cfg_valid/cfg_ready cfg_index (0 width, 1 height), cfg_data[11:0]
//
// A pixel that yields no code passes the read, gradient, multiply and sum
// steps; an interior pixel then runs the 23 table constants through one pair
// of 26x17 multipliers in the angle search: high/low product, sum, compare.
// rst_n is asynchronous; the line stores are not cleared and are filled by the
// first rows of each image. A stalled result waits in the output register while
// the next pixel is taken; in_stall stays high while the block computes and while
// a finished code waits for the output register to empty.
`default_nettype none

module gradient_orientation_map_unit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [gom_pkg::PIX_W-1:0] pixel,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [gom_pkg::CODE_W-1:0]     orient_code,
    output logic [gom_pkg::COL_W-1:0]      col,
    output logic [gom_pkg::ROW_W-1:0]      row,
    output logic                           frame_last,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic                      cfg_index,
    input  wire logic [gom_pkg::ROW_W-1:0] cfg_data
);
    import gom_pkg::*;

    gom_cmd_t  cmd;
    gom_stat_t st;

    assign cfg_ready = 1'b1;

    gom_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    gom_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel       (pixel),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .orient_code (orient_code),
        .col         (col),
        .row         (row),
        .frame_last  (frame_last)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/gom_checker.sv =====
`default_nettype none

module gom_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [7:0]  orient_code,
    input wire logic [9:0]  col,
    input wire logic [11:0] row
);

    // A result held by the consumer stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(orient_code))
        else $error("stalled result changed");

    // Codes stay within the quantizer range
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> orient_code >= 8'd74 && orient_code <= 8'd252)
        else $error("orientation code out of range");

    // Only interior positions are reported
    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> col >= 10'd2 && row >= 12'd2)
        else $error("border position reported");

    // After a pixel transaction the block is busy for the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second pixel taken back to back");

endmodule

bind gradient_orientation_map_unit gom_checker u_chk (.*);

`default_nettype wire
